// ----- design/tked_pkg.sv -----
// Shared types, key codes, character constants and key lookups for the escape decoder.
package tked_pkg;

   typedef logic [3:0] key_kind_type;

   localparam key_kind_type K_BYTE  = 4'd0;
   localparam key_kind_type K_ESC   = 4'd1;
   localparam key_kind_type K_UP    = 4'd2;
   localparam key_kind_type K_DOWN  = 4'd3;
   localparam key_kind_type K_RIGHT = 4'd4;
   localparam key_kind_type K_LEFT  = 4'd5;
   localparam key_kind_type K_HOME  = 4'd6;
   localparam key_kind_type K_END   = 4'd7;
   localparam key_kind_type K_DEL   = 4'd8;
   localparam key_kind_type K_PGUP  = 4'd9;
   localparam key_kind_type K_PGDN  = 4'd10;
   localparam key_kind_type K_MOUSE = 4'd11;

   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_BRACKET = 8'h5B;  // '['
   localparam logic [7:0] CH_LT      = 8'h3C;  // '<'
   localparam logic [7:0] CH_SS3     = 8'h4F;  // 'O'
   localparam logic [7:0] CH_TILDE   = 8'h7E;  // '~'
   localparam logic [7:0] CH_SEMI    = 8'h3B;  // ';'
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_BIG_M   = 8'h4D;
   localparam logic [7:0] CH_SMALL_M = 8'h6D;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_B       = 8'h42;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_D       = 8'h44;
   localparam logic [7:0] CH_F       = 8'h46;
   localparam logic [7:0] CH_H       = 8'h48;
   localparam logic [7:0] CH_1       = 8'h31;
   localparam logic [7:0] CH_3       = 8'h33;
   localparam logic [7:0] CH_4       = 8'h34;
   localparam logic [7:0] CH_5       = 8'h35;
   localparam logic [7:0] CH_6       = 8'h36;
   localparam logic [7:0] CH_7       = 8'h37;
   localparam logic [7:0] CH_8       = 8'h38;

   typedef struct packed {
      logic               valid;
      key_kind_type       kind;
      logic [7:0]         key_byte;
      logic signed [16:0] mouse_col;
      logic signed [16:0] mouse_row;
      logic [15:0]        mouse_btn;
   } res_type;

   function automatic key_kind_type tilde_key(input logic [7:0] d);
      key_kind_type k;
      unique case (d)
         CH_1, CH_7: k = K_HOME;
         CH_3:       k = K_DEL;
         CH_4, CH_8: k = K_END;
         CH_5:       k = K_PGUP;
         CH_6:       k = K_PGDN;
         default:    k = K_ESC;
      endcase
      return k;
   endfunction

   function automatic key_kind_type bracket_key(input logic [7:0] b);
      key_kind_type k;
      unique case (b)
         CH_A:    k = K_UP;
         CH_B:    k = K_DOWN;
         CH_C:    k = K_RIGHT;
         CH_D:    k = K_LEFT;
         CH_H:    k = K_HOME;
         CH_F:    k = K_END;
         default: k = K_ESC;
      endcase
      return k;
   endfunction

endpackage

// ----- design/tked_parse.sv -----
// Escape sequence parser: state registers and per-item next-state and result logic.
module tked_parse #(
   parameter int MAX_BODY = 63
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_accept,
   input  logic             item_timeout,
   input  logic [7:0]       item_byte,
   output tked_pkg::res_type res
);
   import tked_pkg::*;

   localparam int CW = $clog2(MAX_BODY + 1);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_ESC1  = 3'd1;
   localparam logic [2:0] PH_ESC2  = 3'd2;
   localparam logic [2:0] PH_TILDE = 3'd3;
   localparam logic [2:0] PH_MOUSE = 3'd4;

   localparam logic [1:0] IDX_DONE = 2'd3;

   logic [2:0]         phase_ff, phase_in;
   logic [7:0]         second_ff, second_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [15:0]        acc_ff [3];
   logic [15:0]        acc_in [3];
   logic [1:0]         idx_ff, idx_in;
   logic               seen_ff, seen_in;
   logic               failed_ff, failed_in;
   logic signed [16:0] col_ff, col_in;
   logic signed [16:0] row_ff, row_in;
   logic [15:0]        btn_ff, btn_in;

   logic        is_digit;
   logic [15:0] acc_sel;
   logic [19:0] acc_wide;
   logic [15:0] acc_sat;
   logic        finish;
   logic        big_m;
   logic        parse_ok;

   assign is_digit = (item_byte >= CH_ZERO) && (item_byte <= CH_NINE);

   always_comb begin
      case (idx_ff)
         2'd0:    acc_sel = acc_ff[0];
         2'd1:    acc_sel = acc_ff[1];
         default: acc_sel = acc_ff[2];
      endcase
      // x*10 as x*8 + x*2, plus the digit value
      acc_wide = 20'({acc_sel, 3'b000}) + 20'({acc_sel, 1'b0}) + 20'(item_byte[3:0]);
      acc_sat  = (acc_wide > 20'hFFFF) ? 16'hFFFF : acc_wide[15:0];
   end

   always_comb begin
      phase_in  = phase_ff;
      second_in = second_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      idx_in    = idx_ff;
      seen_in   = seen_ff;
      failed_in = failed_ff;
      finish    = 1'b0;
      big_m     = 1'b0;

      res           = '0;
      res.kind      = K_ESC;

      if (item_accept) begin
         unique case (phase_ff)
            PH_ESC1: begin
               if (item_timeout) begin
                  res.valid = 1'b1;
               end else begin
                  second_in = item_byte;
                  phase_in  = PH_ESC2;
               end
            end
            PH_ESC2: begin
               if (item_timeout) begin
                  res.valid = 1'b1;
               end else if (second_ff == CH_BRACKET && item_byte == CH_LT) begin
                  phase_in  = PH_MOUSE;
                  count_in  = '0;
                  acc_in[0] = '0;
                  acc_in[1] = '0;
                  acc_in[2] = '0;
                  idx_in    = '0;
                  seen_in   = 1'b0;
                  failed_in = 1'b0;
               end else if (second_ff == CH_BRACKET && is_digit) begin
                  second_in = item_byte;
                  phase_in  = PH_TILDE;
               end else if (second_ff == CH_BRACKET) begin
                  res.valid = 1'b1;
                  res.kind  = bracket_key(item_byte);
               end else begin
                  res.valid = 1'b1;
                  if (second_ff == CH_SS3 && item_byte == CH_H) begin
                     res.kind = K_HOME;
                  end else if (second_ff == CH_SS3 && item_byte == CH_F) begin
                     res.kind = K_END;
                  end
               end
            end
            PH_TILDE: begin
               res.valid = 1'b1;
               if (!item_timeout && item_byte == CH_TILDE) begin
                  res.kind = tilde_key(second_ff);
               end
            end
            PH_MOUSE: begin
               if (item_timeout || item_byte == CH_SMALL_M) begin
                  finish = 1'b1;
               end else if (item_byte == CH_BIG_M) begin
                  finish = 1'b1;
                  big_m  = 1'b1;
               end else begin
                  if (!failed_ff && idx_ff != IDX_DONE) begin
                     if (is_digit) begin
                        case (idx_ff)
                           2'd0:    acc_in[0] = acc_sat;
                           2'd1:    acc_in[1] = acc_sat;
                           default: acc_in[2] = acc_sat;
                        endcase
                        seen_in = 1'b1;
                     end else if (item_byte == CH_SEMI && idx_ff < 2'd2) begin
                        if (!seen_ff) begin
                           failed_in = 1'b1;
                        end else begin
                           idx_in  = idx_ff + 2'd1;
                           seen_in = 1'b0;
                        end
                     end else if (idx_ff == 2'd2 && seen_ff) begin
                        idx_in = IDX_DONE;
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  count_in = count_ff + CW'(1);
                  if (count_in >= CW'(MAX_BODY)) begin
                     finish = 1'b1;
                  end
               end
            end
            default: begin
               if (!item_timeout) begin
                  if (item_byte == CH_ESC) begin
                     phase_in = PH_ESC1;
                  end else begin
                     res.valid    = 1'b1;
                     res.kind     = K_BYTE;
                     res.key_byte = item_byte;
                  end
               end
            end
         endcase
      end

      parse_ok = !failed_in && (idx_in == IDX_DONE || (idx_in == 2'd2 && seen_in));
      col_in   = col_ff;
      row_in   = row_ff;
      btn_in   = btn_ff;
      if (finish) begin
         res.valid = 1'b1;
         if (parse_ok) begin
            btn_in = acc_in[0];
            col_in = $signed({1'b0, acc_in[1]}) - 17'sd1;
            row_in = $signed({1'b0, acc_in[2]}) - 17'sd1;
            if (big_m) begin
               res.kind = K_MOUSE;
            end
         end
      end
      if (res.valid) begin
         phase_in = PH_IDLE;
      end
      res.mouse_col = col_in;
      res.mouse_row = row_in;
      res.mouse_btn = btn_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         second_ff <= '0;
         count_ff  <= '0;
         acc_ff[0] <= '0;
         acc_ff[1] <= '0;
         acc_ff[2] <= '0;
         idx_ff    <= '0;
         seen_ff   <= 1'b0;
         failed_ff <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         btn_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         second_ff <= second_in;
         count_ff  <= count_in;
         acc_ff    <= acc_in;
         idx_ff    <= idx_in;
         seen_ff   <= seen_in;
         failed_ff <= failed_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         btn_ff    <= btn_in;
      end
   end

`ifndef SYNTH
   // a mouse body never holds the byte that should have closed it
   a_body_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_MOUSE |-> count_ff < CW'(MAX_BODY))
      else $error("mouse body count reached limit without closing");

   // the third number can only complete on a clean parse
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      idx_ff == IDX_DONE |-> !failed_ff)
      else $error("number index done with parse failure set");

   // only plain bytes carry a byte value
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.kind != K_BYTE |-> res.key_byte == 8'd0)
      else $error("non-byte key with nonzero byte value");

   // a result always returns the parser to idle
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      res.valid |=> phase_ff == PH_IDLE)
      else $error("parser not idle after a result");
`endif

endmodule

// ----- design/terminal_key_escape_decoder.sv -----
// Top level of the terminal key escape decoder: parser plus two-entry result queue.
//
//   channel  dir  tdata                          tuser
//   req_     in   in_byte                        op (1 = read timeout)
//   rsp_     out  kind, byte, col, row, btn      -
//
// One item per cycle while req_tready is high; each item is parsed in the cycle it is accepted and
// its result, if any, shows on rsp_ the next cycle unless an earlier result
// is still waiting there.
// The result side is an output register plus one skid entry, so input is
// taken while one result waits; req_tready drops only when both are full.
// Reset is synchronous: parser idle, all numbers and mouse registers zero.
module terminal_key_escape_decoder #(
   parameter int MAX_BODY = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [3:0] key_kind, [11:4] key_byte, [28:12] mouse_col,
                                    // [45:29] mouse_row, [61:46] mouse_btn, [63:62] zero
);
   import tked_pkg::*;

   res_type     res;
   logic        accept;
   logic        push;
   logic        pop;
   logic [63:0] new_data;

   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff, out_data_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [63:0] skid_data_ff, skid_data_in;

   assign accept = req_tvalid && req_tready;

   tked_parse #(
      .MAX_BODY(MAX_BODY)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .item_accept (accept),
      .item_timeout(req_tuser),
      .item_byte   (req_tdata),
      .res         (res)
   );

   assign new_data = {2'b00, res.mouse_btn, res.mouse_row, res.mouse_col,
                      res.key_byte, res.kind};
   assign push     = res.valid;
   assign pop      = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in = skid_data_ff;
            if (push) begin
               skid_data_in = new_data;
            end else begin
               skid_valid_in = 1'b0;
            end
         end else if (push) begin
            out_data_in = new_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = new_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = new_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- test/key_decode_checker.sv -----
// Checker for the escape decoder: predicts decoded keys from accepted bytes and compares results.
module key_decode_checker #(
   parameter int MAX_BODY = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [3:0] key_kind, [11:4] key_byte, [28:12] mouse_col,
                                    // [45:29] mouse_row, [61:46] mouse_btn
   output int          fail_count,
   output int          pending
);
   import tked_pkg::*;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_ESC,
      SCAN_INTRO,
      SCAN_TILDE,
      SCAN_MOUSE
   } scan_state_type;

   typedef struct packed {
      key_kind_type kind;
      logic [7:0]   key_byte;
      logic [16:0]  col;
      logic [16:0]  row;
      logic [15:0]  btn;
   } key_item_type;

   scan_state_type scan;
   logic [7:0]  lead;
   logic [5:0]  body_len;
   logic [15:0] nums [3];
   logic [1:0]  num_sel;
   logic        have_digit;
   logic        bad;
   logic [16:0] col_reg;
   logic [16:0] row_reg;
   logic [15:0] btn_reg;

   key_item_type expected_keys [$];
   int errors = 0;
   int waiting = 0;

   assign fail_count = errors;
   assign pending = waiting;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (errors < 100)
         $display("checker: %s got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   // Advances the decoder state by one item; returns 1 when a key comes out.
   function automatic bit decode_step(input bit tmo, input logic [7:0] b, output key_item_type k);
      bit           hit;
      bit           close_body;
      bit           big_m;
      bit           good;
      key_kind_type kind;
      logic [7:0]   out_byte;
      logic [19:0]  v;
      hit = 1'b0;
      close_body = 1'b0;
      big_m = 1'b0;
      kind = K_ESC;
      out_byte = 8'd0;
      k = '0;
      case (scan)
         SCAN_ESC: begin
            if (tmo) hit = 1'b1;
            else begin
               lead = b;
               scan = SCAN_INTRO;
            end
         end
         SCAN_INTRO: begin
            if (tmo) hit = 1'b1;
            else if (lead == CH_BRACKET) begin
               if (b == CH_LT) begin
                  scan = SCAN_MOUSE;
                  body_len = '0;
                  nums[0] = '0;
                  nums[1] = '0;
                  nums[2] = '0;
                  num_sel = '0;
                  have_digit = 1'b0;
                  bad = 1'b0;
               end else if (b >= CH_ZERO && b <= CH_NINE) begin
                  lead = b;
                  scan = SCAN_TILDE;
               end else begin
                  hit = 1'b1;
                  case (b)
                     CH_A: kind = K_UP;
                     CH_B: kind = K_DOWN;
                     CH_C: kind = K_RIGHT;
                     CH_D: kind = K_LEFT;
                     CH_H: kind = K_HOME;
                     CH_F: kind = K_END;
                     default: kind = K_ESC;
                  endcase
               end
            end else begin
               hit = 1'b1;
               if (lead == CH_SS3 && b == CH_H) kind = K_HOME;
               else if (lead == CH_SS3 && b == CH_F) kind = K_END;
            end
         end
         SCAN_TILDE: begin
            hit = 1'b1;
            if (!tmo && b == CH_TILDE) begin
               case (lead)
                  CH_1, CH_7: kind = K_HOME;
                  CH_3:       kind = K_DEL;
                  CH_4, CH_8: kind = K_END;
                  CH_5:       kind = K_PGUP;
                  CH_6:       kind = K_PGDN;
                  default:    kind = K_ESC;
               endcase
            end
         end
         SCAN_MOUSE: begin
            if (tmo) close_body = 1'b1;
            else if (b == CH_BIG_M) begin
               close_body = 1'b1;
               big_m = 1'b1;
            end else if (b == CH_SMALL_M) close_body = 1'b1;
            else begin
               // bytes after a complete third number are ignored
               if (!bad && num_sel < 2'd3) begin
                  if (b >= CH_ZERO && b <= CH_NINE) begin
                     v = 20'(nums[num_sel]) * 20'd10 + 20'(b - CH_ZERO);
                     nums[num_sel] = (v > 20'd65535) ? 16'hFFFF : v[15:0];
                     have_digit = 1'b1;
                  end else if (b == CH_SEMI && num_sel < 2'd2) begin
                     if (!have_digit) bad = 1'b1;
                     else begin
                        num_sel++;
                        have_digit = 1'b0;
                     end
                  end else if (num_sel == 2'd2 && have_digit) num_sel = 2'd3;
                  else bad = 1'b1;
               end
               body_len++;
               if (body_len >= 6'(MAX_BODY)) close_body = 1'b1;
            end
         end
         default: begin
            scan = SCAN_IDLE;
            if (!tmo) begin
               if (b == CH_ESC) scan = SCAN_ESC;
               else begin
                  hit = 1'b1;
                  kind = K_BYTE;
                  out_byte = b;
               end
            end
         end
      endcase
      if (close_body) begin
         good = !bad && (num_sel == 2'd3 || (num_sel == 2'd2 && have_digit));
         if (good) begin
            btn_reg = nums[0];
            col_reg = {1'b0, nums[1]} - 17'd1;
            row_reg = {1'b0, nums[2]} - 17'd1;
         end
         hit = 1'b1;
         kind = (good && big_m) ? K_MOUSE : K_ESC;
      end
      if (hit) begin
         k.kind = kind;
         k.key_byte = out_byte;
         k.col = col_reg;
         k.row = row_reg;
         k.btn = btn_reg;
         scan = SCAN_IDLE;
      end
      return hit;
   endfunction

   always @(posedge clock) begin
      key_item_type got;
      key_item_type want;
      key_item_type pred;
      if (reset) begin
         scan = SCAN_IDLE;
         lead = '0;
         body_len = '0;
         nums[0] = '0;
         nums[1] = '0;
         nums[2] = '0;
         num_sel = '0;
         have_digit = 1'b0;
         bad = 1'b0;
         col_reg = '0;
         row_reg = '0;
         btn_reg = '0;
         expected_keys.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tdata[3:0];
            got.key_byte = rsp_tdata[11:4];
            got.col = rsp_tdata[28:12];
            got.row = rsp_tdata[45:29];
            got.btn = rsp_tdata[61:46];
            if (expected_keys.size() == 0)
               report_mismatch("key with none pending, kind", got.kind, 0);
            else begin
               want = expected_keys.pop_front();
               if (got.kind != want.kind) report_mismatch("key_kind", got.kind, want.kind);
               if (got.key_byte != want.key_byte)
                  report_mismatch("key_byte", got.key_byte, want.key_byte);
               if (got.col != want.col) report_mismatch("mouse_col", got.col, want.col);
               if (got.row != want.row) report_mismatch("mouse_row", got.row, want.row);
               if (got.btn != want.btn) report_mismatch("mouse_btn", got.btn, want.btn);
            end
         end
         if (req_tvalid && req_tready) begin
            if (decode_step(req_tuser, req_tdata, pred)) expected_keys.push_back(pred);
         end
      end
      waiting <= expected_keys.size();
   end

endmodule

// ----- test/testbench.sv -----
// Top of the escape decoder test: clock, reset, byte stimulus, receiver stalls and verdict.
module testbench;
   import tked_pkg::*;

   localparam int MAX_BODY = 63;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   int fail_count;
   int pending;
   int send_idle_pct = 19;
   int recv_idle_pct = 68;
   int items_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   terminal_key_escape_decoder #(.MAX_BODY(MAX_BODY)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   key_decode_checker #(.MAX_BODY(MAX_BODY)) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .fail_count(fail_count),
      .pending(pending)
   );

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic send_item(input bit op, input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata = 8'($urandom);
         req_tuser = 1'($urandom);
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tuser = op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(1'b0, b);
   endtask

   task automatic send_timeout();
      send_item(1'b1, 8'($urandom));
   endtask

   // byte inside a sequence, now and then replaced by a read timeout
   task automatic send_sym(input logic [7:0] b);
      if ($urandom_range(29) == 0) send_timeout();
      else send_byte(b);
   endtask

   task automatic send_number();
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
      repeat (n) send_sym(CH_ZERO + 8'($urandom_range(9)));
   endtask

   initial begin
      logic [7:0] arrow_finals [6];
      logic [7:0] tilde_digits [8];
      int         flaw;
      int         term;
      arrow_finals = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
      tilde_digits = '{CH_1, CH_3, CH_4, CH_5, CH_6, CH_7, CH_8, CH_ZERO};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes of the byte, timeouts idle and mid-sequence, each sequence form
      send_byte(8'h00);
      send_byte(8'hFF);
      send_timeout();
      send_byte(CH_ESC);
      send_timeout();
      send_byte(CH_ESC); send_byte(CH_BRACKET); send_byte(CH_A);
      send_byte(CH_ESC); send_byte(CH_BRACKET); send_byte(CH_6); send_byte(CH_TILDE);
      send_byte(CH_ESC); send_byte(CH_SS3); send_byte(CH_H);
      // zero coordinates give -1 in the column and row registers
      send_byte(CH_ESC); send_byte(CH_BRACKET); send_byte(CH_LT);
      send_byte(CH_ZERO); send_byte(CH_SEMI); send_byte(CH_ZERO); send_byte(CH_SEMI);
      send_byte(CH_ZERO); send_byte(CH_BIG_M);

      while (items_sent < 824) begin
         if (items_sent >= 580) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (items_sent >= 300) begin
            send_idle_pct = 68;
            recv_idle_pct = 19;
         end
         case ($urandom_range(9))
            0, 1: send_byte(8'($urandom));
            2: send_timeout();
            3: begin
               send_byte(CH_ESC);
               send_sym(CH_BRACKET);
               if ($urandom_range(5) == 0) send_sym(8'($urandom));
               else send_sym(arrow_finals[$urandom_range(5)]);
            end
            4: begin
               send_byte(CH_ESC);
               send_sym(CH_BRACKET);
               send_sym(($urandom_range(7) == 0) ? CH_ZERO + 8'($urandom_range(9))
                                                 : tilde_digits[$urandom_range(7)]);
               send_sym(($urandom_range(5) == 0) ? 8'($urandom) : CH_TILDE);
            end
            5: begin
               send_byte(CH_ESC);
               send_sym(CH_SS3);
               case ($urandom_range(2))
                  0: send_sym(CH_H);
                  1: send_sym(CH_F);
                  default: send_sym(8'($urandom));
               endcase
            end
            6: begin
               send_byte(CH_ESC);
               send_sym(8'($urandom));
               send_sym(8'($urandom));
            end
            7, 8: begin
               send_byte(CH_ESC);
               send_sym(CH_BRACKET);
               send_sym(CH_LT);
               flaw = $urandom_range(11);
               send_number();
               send_sym(CH_SEMI);
               if (flaw != 1) send_number();
               if (flaw == 0) send_sym(8'($urandom));
               send_sym(CH_SEMI);
               send_number();
               if (flaw == 2) repeat ($urandom_range(1, 5)) send_sym(8'($urandom));
               // overlong body: usually ends on the byte count alone
               if (flaw == 3) begin
                  repeat ($urandom_range(55, 70)) begin
                     if ($urandom_range(3) == 0) send_byte(8'($urandom));
                     else send_byte(CH_ZERO + 8'($urandom_range(9)));
                  end
               end
               term = $urandom_range(9);
               if (term < 7) send_sym(CH_BIG_M);
               else if (term == 7) send_sym(CH_SMALL_M);
               else if (term == 8) send_timeout();
            end
            default: begin
               send_byte(CH_ESC);
               if ($urandom_range(1)) send_byte(CH_BRACKET);
               send_timeout();
            end
         endcase
      end
      send_timeout();
      @(negedge clock);
      req_tvalid = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("terminal_key_escape_decoder: match");
      else
         $display("terminal_key_escape_decoder: mismatch");
      $finish;
   end

   initial begin
      #3000000;
      $display("terminal_key_escape_decoder: mismatch");
      $finish;
   end

endmodule
